@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition never holds
`define AST_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed");

`endif

@@ hdl/evp_pkg.sv @@
// types and constants of the encoder valve positioner
// no dependencies
`timescale 1ns / 1ps

package evp_pkg;

    localparam int KIND_BITS   = 4;
    localparam int FIELD_BITS  = 16;
    localparam int TDATA_BITS  = 24;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_EDGE   = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_START  = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_STOP   = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_GOTO   = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_OPEN   = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE  = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_ZERO   = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_CHECK  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 4'd8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSED = 2'd1;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_STALL     = 2'd1;
    localparam logic [1:0] FAULT_WRONG_DIR = 2'd2;

    typedef enum logic [2:0] {
        OP_EDGE,
        OP_START,
        OP_STOP,
        OP_SEEK,
        OP_ZERO,
        OP_CHECK,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CW   = 2'd1,
        MODE_CCW  = 2'd2
    } t_mode;

    // dir: encoder b for an edge, ccw request for a start
    typedef struct packed {
        t_op  op;
        logic dir;
    } t_cmd;

endpackage

@@ hdl/evp_front.sv @@
// front end: preset registers and event decode into queue commands
// depends on evp_pkg
`timescale 1ns / 1ps

module evp_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [evp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [evp_pkg::FIELD_BITS-1:0]        i_cfg_data,
    input  logic [evp_pkg::TDATA_BITS-1:0]        i_data,
    input  logic [evp_pkg::KIND_BITS-1:0]         i_kind,
    output evp_pkg::t_cmd                         o_cmd,
    output logic [POSITION_BITS-1:0]              o_goal
);

    logic signed [evp_pkg::FIELD_BITS-1:0] r_open;
    logic signed [evp_pkg::FIELD_BITS-1:0] r_closed;
    logic signed [evp_pkg::FIELD_BITS-1:0] w_src;
    logic signed [evp_pkg::FIELD_BITS-1:0] w_target;

    assign o_cfg_ready = 1'b1;
    assign w_target    = $signed(i_data[17:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_closed <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == evp_pkg::CFG_OPEN) begin
                r_open <= i_cfg_data;
            end
            if (i_cfg_index == evp_pkg::CFG_CLOSED) begin
                r_closed <= i_cfg_data;
            end
        end
    end

    always_comb begin
        o_cmd.dir = 1'b0;
        w_src     = w_target;
        unique case (i_kind)
            evp_pkg::KIND_EDGE: begin
                o_cmd.op  = evp_pkg::OP_EDGE;
                o_cmd.dir = i_data[0];
            end
            evp_pkg::KIND_START: begin
                o_cmd.op  = evp_pkg::OP_START;
                o_cmd.dir = i_data[1];
            end
            evp_pkg::KIND_STOP:  o_cmd.op = evp_pkg::OP_STOP;
            evp_pkg::KIND_GOTO:  o_cmd.op = evp_pkg::OP_SEEK;
            evp_pkg::KIND_OPEN: begin
                o_cmd.op = evp_pkg::OP_SEEK;
                w_src    = r_open;
            end
            evp_pkg::KIND_CLOSE: begin
                o_cmd.op = evp_pkg::OP_SEEK;
                w_src    = r_closed;
            end
            evp_pkg::KIND_ZERO:  o_cmd.op = evp_pkg::OP_ZERO;
            evp_pkg::KIND_CHECK: o_cmd.op = evp_pkg::OP_CHECK;
            evp_pkg::KIND_CLEAR: o_cmd.op = evp_pkg::OP_CLEAR;
            default:             o_cmd.op = evp_pkg::OP_NONE;
        endcase
    end

    // sign-extend or wrap the 16-bit goal to the count width
    assign o_goal = POSITION_BITS'(w_src);

endmodule

@@ hdl/evp_queue.sv @@
// small register queue between front end and back end
// no dependencies
`timescale 1ns / 1ps

module evp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wptr;
    logic [PTR_BITS-1:0] n_rptr;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ hdl/evp_back.sv @@
// back end: position, drive and fault state, result register
// depends on evp_pkg
`timescale 1ns / 1ps

module evp_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  evp_pkg::t_cmd                  i_cmd,
    input  logic [POSITION_BITS-1:0]       i_goal,
    output logic                           o_pop,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [evp_pkg::TDATA_BITS-1:0] o_m_axis_tdata
);

    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] r_goal;
    logic [POSITION_BITS-1:0] r_last;
    logic                     r_seeking;
    logic [1:0]               r_fault;
    evp_pkg::t_mode           r_mode;

    logic [POSITION_BITS-1:0] n_count;
    logic [POSITION_BITS-1:0] n_goal;
    logic [POSITION_BITS-1:0] n_last;
    logic                     n_seeking;
    logic [1:0]               n_fault;
    evp_pkg::t_mode           n_mode;

    logic                     w_halt;
    logic                     w_begin;
    logic                     w_begin_ccw;
    logic                     w_cw;
    logic                     w_ccw;

    logic                           r_out_valid;
    logic [evp_pkg::TDATA_BITS-1:0] r_out_data;

    assign o_pop = i_valid && (!r_out_valid || i_m_axis_tready);

    // datapath for one command
    always_comb begin
        n_count     = r_count;
        n_goal      = r_goal;
        n_last      = r_last;
        n_seeking   = r_seeking;
        n_fault     = r_fault;
        w_halt      = 1'b0;
        w_begin     = 1'b0;
        w_begin_ccw = 1'b0;
        unique case (i_cmd.op)
            evp_pkg::OP_EDGE: begin
                if (i_cmd.dir) begin
                    n_count = r_count - 1'b1;
                    w_halt  = r_seeking && ($signed(n_count) <= $signed(r_goal));
                end else begin
                    n_count = r_count + 1'b1;
                    w_halt  = r_seeking && ($signed(n_count) >= $signed(r_goal));
                end
            end
            evp_pkg::OP_START: begin
                w_begin     = 1'b1;
                w_begin_ccw = i_cmd.dir;
            end
            evp_pkg::OP_STOP: w_halt = 1'b1;
            evp_pkg::OP_SEEK: begin
                n_goal      = i_goal;
                n_seeking   = 1'b1;
                w_begin     = ($signed(i_goal) != $signed(r_count));
                w_begin_ccw = ($signed(i_goal) < $signed(r_count));
            end
            evp_pkg::OP_ZERO:  n_count = '0;
            evp_pkg::OP_CHECK: begin
                if (r_fault == evp_pkg::FAULT_NONE && r_mode != evp_pkg::MODE_STOP) begin
                    if (r_count == r_last) begin
                        n_fault = evp_pkg::FAULT_STALL;
                    end else if ((r_mode == evp_pkg::MODE_CW)
                                 ? ($signed(r_count) < $signed(r_last))
                                 : ($signed(r_count) > $signed(r_last))) begin
                        n_fault = evp_pkg::FAULT_WRONG_DIR;
                    end
                    n_last = r_count;
                end
                w_halt = (n_fault != evp_pkg::FAULT_NONE);
            end
            evp_pkg::OP_CLEAR: n_fault = evp_pkg::FAULT_NONE;
            default: ;
        endcase
        if (w_halt) begin
            n_seeking = 1'b0;
        end
    end

    // drive mode next state
    always_comb begin
        n_mode = r_mode;
        priority if (w_halt) begin
            n_mode = evp_pkg::MODE_STOP;
        end else if (w_begin && r_fault != evp_pkg::FAULT_NONE) begin
            n_mode = evp_pkg::MODE_STOP;
        end else if (w_begin) begin
            n_mode = w_begin_ccw ? evp_pkg::MODE_CCW : evp_pkg::MODE_CW;
        end
    end

    // drive outputs from mode
    always_comb begin
        w_cw  = 1'b0;
        w_ccw = 1'b0;
        unique case (n_mode)
            evp_pkg::MODE_CW:  w_cw  = 1'b1;
            evp_pkg::MODE_CCW: w_ccw = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_goal      <= '0;
            r_last      <= '0;
            r_seeking   <= 1'b0;
            r_fault     <= evp_pkg::FAULT_NONE;
            r_mode      <= evp_pkg::MODE_STOP;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count   <= n_count;
                r_goal    <= n_goal;
                r_last    <= n_last;
                r_seeking <= n_seeking;
                r_fault   <= n_fault;
                r_mode    <= n_mode;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {3'b000, n_seeking, n_fault,
                           evp_pkg::FIELD_BITS'(n_count), w_ccw, w_cw};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ hdl/encoder_valve_positioner.sv @@
// top level of the encoder valve positioner
// depends on evp_pkg, evp_front, evp_queue, evp_back, assert_macros.svh
`timescale 1ns / 1ps

// Each event word (encoder edge or command) gives exactly one result word.
// Throughput is one word per cycle while the output sink keeps tready high. An
// accepted word is written as a decoded command into the four-entry command
// queue, and the back end pops it through the state update into the result
// register. While the result word waits, the queue takes up to four more
// words before the input stalls. The position counter and its compare
// against goal and last check set the critical path. The user must see
// that presets are written on the config port while no word is in flight;
// the block itself does not enforce it. Writes are always accepted.
module encoder_valve_positioner #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: encoder_b[0], counter_clockwise[1], target[17:2], zero fill
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [evp_pkg::TDATA_BITS-1:0]      i_s_axis_tdata,
    // tuser: kind[3:0]
    input  logic [evp_pkg::KIND_BITS-1:0]       i_s_axis_tuser,
    // tdata: drive_cw[0], drive_ccw[1], position[17:2], error_code[19:18],
    //        target_pending[20], zero fill
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [evp_pkg::TDATA_BITS-1:0]      o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [evp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [evp_pkg::FIELD_BITS-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_BITS    = $bits(evp_pkg::t_cmd);
    localparam int ENTRY_BITS  = CMD_BITS + POSITION_BITS;

    evp_pkg::t_cmd            w_front_cmd;
    logic [POSITION_BITS-1:0] w_front_goal;
    logic                     w_push;
    logic                     w_full;
    logic                     w_q_valid;
    logic                     w_pop;
    logic [ENTRY_BITS-1:0]    w_q_data;
    evp_pkg::t_cmd            w_back_cmd;
    logic [POSITION_BITS-1:0] w_back_goal;

    assign o_s_axis_tready = !w_full;
    assign w_push          = i_s_axis_tvalid && !w_full;

    evp_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_s_axis_tdata),
        .i_kind      (i_s_axis_tuser),
        .o_cmd       (w_front_cmd),
        .o_goal      (w_front_goal)
    );

    evp_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_cmd, w_front_goal}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_back_cmd  = evp_pkg::t_cmd'(w_q_data[ENTRY_BITS-1:POSITION_BITS]);
    assign w_back_goal = w_q_data[POSITION_BITS-1:0];

    evp_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_cmd           (w_back_cmd),
        .i_goal          (w_back_goal),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    `AST_NEVER(a_drive_exclusive, i_clk, i_rst_n,
               o_m_axis_tvalid && o_m_axis_tdata[0] && o_m_axis_tdata[1])
    `AST_NEVER(a_fault_code_range, i_clk, i_rst_n,
               o_m_axis_tvalid && o_m_axis_tdata[19] && o_m_axis_tdata[18])
    `AST_IMPLY(a_fault_stops_drive, i_clk, i_rst_n,
               o_m_axis_tvalid && (o_m_axis_tdata[19] || o_m_axis_tdata[18]),
               !o_m_axis_tdata[0] && !o_m_axis_tdata[1])
    `AST_NEVER(a_queue_pop_empty, i_clk, i_rst_n, w_pop && !w_q_valid)

endmodule

@@ dv/tb.sv @@
// self-checking testbench for encoder_valve_positioner
// predicts every status word from the event stream and compares field by field
// depends on evp_pkg and the rtl of encoder_valve_positioner
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 285;

    typedef struct {
        logic        cw;
        logic        ccw;
        logic [15:0] position;
        logic [1:0]  code;
        logic        pending;
    } t_status;

    class t_status_predictor;
        logic signed [15:0] count;
        logic signed [15:0] goal;
        logic signed [15:0] last_check;
        logic signed [15:0] open_pos;
        logic signed [15:0] closed_pos;
        evp_pkg::t_mode     mode;
        bit                 seeking;
        logic [1:0]         fault;
        t_status            expected_status[$];
        int                 errors;

        function new();
            count      = '0;
            goal       = '0;
            last_check = '0;
            open_pos   = '0;
            closed_pos = '0;
            mode       = evp_pkg::MODE_STOP;
            seeking    = 1'b0;
            fault      = evp_pkg::FAULT_NONE;
            errors     = 0;
        endfunction

        function void set_preset(logic [evp_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
            if (idx == evp_pkg::CFG_OPEN) begin
                open_pos = value;
            end else if (idx == evp_pkg::CFG_CLOSED) begin
                closed_pos = value;
            end
        endfunction

        function void halt_drive();
            seeking = 1'b0;
            mode    = evp_pkg::MODE_STOP;
        endfunction

        // refused while an error is latched
        function void request_drive(bit ccw);
            if (fault != evp_pkg::FAULT_NONE) begin
                mode = evp_pkg::MODE_STOP;
            end else begin
                mode = ccw ? evp_pkg::MODE_CCW : evp_pkg::MODE_CW;
            end
        endfunction

        function void seek_to(logic signed [15:0] where);
            goal = where;
            if (goal < count) begin
                request_drive(1'b1);
            end else if (goal > count) begin
                request_drive(1'b0);
            end
            seeking = 1'b1;
        endfunction

        function void apply_event(logic [evp_pkg::KIND_BITS-1:0] kind, bit b, bit ccw,
                                  logic signed [15:0] target);
            t_status s;
            case (kind)
                evp_pkg::KIND_EDGE: begin
                    if (b) begin
                        count = count - 16'sd1;
                        if (seeking && count <= goal) halt_drive();
                    end else begin
                        count = count + 16'sd1;
                        if (seeking && count >= goal) halt_drive();
                    end
                end
                evp_pkg::KIND_START: request_drive(ccw);
                evp_pkg::KIND_STOP:  halt_drive();
                evp_pkg::KIND_GOTO:  seek_to(target);
                evp_pkg::KIND_OPEN:  seek_to(open_pos);
                evp_pkg::KIND_CLOSE: seek_to(closed_pos);
                evp_pkg::KIND_ZERO:  count = '0;
                evp_pkg::KIND_CHECK: begin
                    if (fault == evp_pkg::FAULT_NONE && mode != evp_pkg::MODE_STOP) begin
                        if (count == last_check) begin
                            fault = evp_pkg::FAULT_STALL;
                        end else if (mode == evp_pkg::MODE_CW ? (count < last_check)
                                                              : (count > last_check)) begin
                            fault = evp_pkg::FAULT_WRONG_DIR;
                        end
                        last_check = count;
                    end
                    if (fault != evp_pkg::FAULT_NONE) halt_drive();
                end
                evp_pkg::KIND_CLEAR: fault = evp_pkg::FAULT_NONE;
                default: ;
            endcase
            s.cw       = (mode == evp_pkg::MODE_CW);
            s.ccw      = (mode == evp_pkg::MODE_CCW);
            s.position = count;
            s.code     = fault;
            s.pending  = seeking;
            expected_status.push_back(s);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [evp_pkg::TDATA_BITS-1:0] word);
            t_status s;
            if (expected_status.size() == 0) begin
                $error("status word with nothing expected: %0h", word);
                errors++;
                return;
            end
            s = expected_status.pop_front();
            compare_field("drive_cw", int'(s.cw), int'(word[0]));
            compare_field("drive_ccw", int'(s.ccw), int'(word[1]));
            compare_field("position", int'($signed(s.position)), int'($signed(word[17:2])));
            compare_field("error_code", int'(s.code), int'(word[19:18]));
            compare_field("target_pending", int'(s.pending), int'(word[20]));
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [evp_pkg::TDATA_BITS-1:0]   i_s_axis_tdata;
    logic [evp_pkg::KIND_BITS-1:0]    i_s_axis_tuser;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [evp_pkg::TDATA_BITS-1:0]   o_m_axis_tdata;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [evp_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [evp_pkg::FIELD_BITS-1:0]   i_cfg_data;

    t_status_predictor status_pred = new();
    int items_sent   = 0;
    int results_seen = 0;
    int tx_quiet     = 0;
    int rx_quiet     = 0;

    encoder_valve_positioner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_event(input logic [evp_pkg::KIND_BITS-1:0] kind, input bit b,
                              input bit ccw, input logic [15:0] target);
        int gap;
        if (tx_quiet > 0) begin
            gap = 0;
            tx_quiet--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) tx_quiet = 25;
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = {6'b0, target, ccw, b};
        do @(posedge i_clk); while (!o_s_axis_tready);
        status_pred.apply_event(kind, b, ccw, target);
        items_sent++;
    endtask

    task automatic write_preset(input logic [evp_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        status_pred.set_preset(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (status_pred.expected_status.size() != 0) @(posedge i_clk);
    endtask

    // one move: a drive request followed by edges, checks and some noise
    task automatic run_episode();
        int pick;
        int steps;
        int r;
        bit down;
        logic [15:0] tgt;
        if (status_pred.fault != evp_pkg::FAULT_NONE && $urandom_range(0, 3) != 0)
            send_event(evp_pkg::KIND_CLEAR, rand_bit(), rand_bit(), rand_word());
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_event(evp_pkg::KIND_GOTO, rand_bit(), rand_bit(), rand_word());
        end else if (pick < 5) begin
            tgt = 16'(int'(status_pred.count) + int'($urandom_range(0, 40)) - 20);
            send_event(evp_pkg::KIND_GOTO, rand_bit(), rand_bit(), tgt);
        end else if (pick < 7) begin
            send_event(pick == 5 ? evp_pkg::KIND_OPEN : evp_pkg::KIND_CLOSE, rand_bit(),
                       rand_bit(), rand_word());
        end else begin
            send_event(evp_pkg::KIND_START, rand_bit(), rand_bit(), rand_word());
        end
        steps = $urandom_range(2, 30);
        repeat (steps) begin
            r = $urandom_range(0, 19);
            if (status_pred.mode == evp_pkg::MODE_STOP) begin
                down = rand_bit();
            end else begin
                down = (status_pred.mode == evp_pkg::MODE_CCW);
            end
            if (r < 13) begin
                send_event(evp_pkg::KIND_EDGE, (r == 0) ? !down : down, rand_bit(),
                           rand_word());
            end else if (r < 17) begin
                send_event(evp_pkg::KIND_CHECK, rand_bit(), rand_bit(), rand_word());
            end else if (r == 17) begin
                send_event(evp_pkg::KIND_STOP, rand_bit(), rand_bit(), rand_word());
            end else begin
                send_event(4'($urandom_range(0, 15)), rand_bit(), rand_bit(), rand_word());
            end
        end
    endtask

    initial begin : status_sink
        int stall;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (results_seen == HOLD_AT) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (rx_quiet > 0) begin
                stall = 0;
                rx_quiet--;
            end else begin
                stall = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0) rx_quiet = 25;
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            status_pred.check_status(o_m_axis_tdata);
            results_seen++;
        end
    end

    initial begin : stimulus
        int phase_end;
        logic [15:0] open_val;
        logic [15:0] closed_val;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_preset(evp_pkg::CFG_OPEN, 16'h7fff);
        write_preset(evp_pkg::CFG_CLOSED, 16'h8000);

        // unused kinds, edges, stall and wrong direction faults, refused start
        send_event(4'd9, 1'b0, 1'b0, 16'h0000);
        send_event(4'd15, 1'b1, 1'b1, 16'hffff);
        send_event(evp_pkg::KIND_EDGE, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_EDGE, 1'b1, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CHECK, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_START, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CHECK, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_START, 1'b0, 1'b1, 16'h0000);
        send_event(evp_pkg::KIND_GOTO, 1'b0, 1'b0, 16'd100);
        send_event(evp_pkg::KIND_CHECK, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CLEAR, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_START, 1'b0, 1'b1, 16'h0000);
        send_event(evp_pkg::KIND_EDGE, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CHECK, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CLEAR, 1'b0, 1'b0, 16'h0000);
        // goto the current count, then an edge past it
        send_event(evp_pkg::KIND_GOTO, 1'b0, 1'b0, 16'd1);
        send_event(evp_pkg::KIND_EDGE, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_ZERO, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_GOTO, 1'b0, 1'b0, 16'h7fff);
        send_event(evp_pkg::KIND_EDGE, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_OPEN, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_CLOSE, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_ZERO, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_STOP, 1'b0, 1'b0, 16'h0000);
        send_event(evp_pkg::KIND_GOTO, 1'b0, 1'b0, 16'h8000);
        finish_phase();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                open_val   = 16'h8000;
                closed_val = 16'h7fff;
            end else if (phase == 1) begin
                open_val   = 16'h0000;
                closed_val = 16'h0000;
            end else begin
                open_val   = 16'(int'($urandom_range(0, 400)) - 200);
                closed_val = 16'(int'($urandom_range(0, 400)) - 200);
            end
            write_preset(evp_pkg::CFG_OPEN, open_val);
            write_preset(evp_pkg::CFG_CLOSED, closed_val);
            if (phase == 1) send_event(evp_pkg::KIND_ZERO, 1'b0, 1'b0, 16'h0000);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_episode();
            finish_phase();
        end

        repeat (6) @(posedge i_clk);
        if (status_pred.errors == 0 && status_pred.expected_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
